[rtl/rtdtm_pkg.sv]
// ----------------------------------------------------------------------------
// rtdtm_pkg: shared types, constants and lookup tables
// Word types, controller states and the two resistance tables.
// ----------------------------------------------------------------------------
package rtdtm_pkg;

  localparam int unsigned WINDOW_DEF   = 32;
  localparam int unsigned TRIM_DEF     = 8;
  localparam int unsigned PT1000_N_DEF = 260;
  localparam int unsigned PT500_N_DEF  = 460;
  localparam int unsigned SBITS_DEF    = 16;

  localparam int unsigned ROM1000_SIZE = 260;
  localparam int unsigned ROM500_SIZE  = 460;

  localparam logic [7:0]  ERR_CODE     = 8'd255;
  localparam logic [2:0]  SEL_PT500    = 3'd5;

  typedef struct packed {
    logic [15:0] sample;
    logic [2:0]  sensor_select;
  } in_word_t;

  typedef struct packed {
    logic [7:0] temperature;
    logic       error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_FILL, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_SUM_RD, ST_SUM,
    ST_DIV, ST_SCALE, ST_SRCH, ST_CMP, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic store_wr;
    logic rd_issue;
    logic sort_init;
    logic sort_step;
    logic sum_init;
    logic sum_acc;
    logic div_start;
    logic scale;
    logic srch_init;
    logic cmp_issue;
    logic cmp_apply;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sort_done;
    logic sum_done;
    logic div_done;
    logic over_limit;
    logic srch_done;
    logic hit;
  } stat_t;

  function automatic logic [20:0] pt1000_val(input logic [8:0] i);
    logic [20:0] t [0:ROM1000_SIZE-1];
    t = '{
1000000,1003908,1007814,1011720,1015624,1019527,1023429,1027330,1031229,1035128,
1039025,1042921,1046816,1050710,1054603,1058495,1062385,1066274,1070162,1074049,
1077935,1081820,1085703,1089585,1093467,1097347,1101225,1105103,1108980,1112855,
1116729,1120602,1124474,1128345,1132215,1136083,1139950,1143817,1147681,1151545,
1155408,1159270,1163130,1166989,1170847,1174704,1178560,1182414,1186268,1190120,
1193971,1197821,1201670,1205518,1209364,1213210,1217054,1220897,1224739,1228579,
1232419,1236257,1240095,1243931,1247766,1251600,1255432,1259264,1263094,1266923,
1270751,1274578,1278404,1282228,1286052,1289874,1293695,1297515,1301334,1305152,
1308968,1312783,1316597,1320411,1324222,1328033,1331843,1335651,1339458,1343264,
1347069,1350873,1354676,1358477,1362277,1366077,1369875,1373671,1377467,1381262,
1385055,1388847,1392638,1396428,1400217,1404005,1407791,1411576,1415360,1419143,
1422925,1426706,1430485,1434264,1438041,1441817,1445592,1449366,1453138,1456910,
1460680,1464449,1468217,1471984,1475750,1479514,1483277,1487040,1490801,1494561,
1498319,1502077,1505833,1509589,1513343,1517096,1520847,1524598,1528381,1532139,
1535843,1539589,1543334,1547078,1550820,1554562,1558302,1562041,1565779,1569516,
1573251,1576986,1580719,1584451,1588182,1591912,1595641,1599368,1603094,1606820,
1610544,1614267,1617989,1621709,1625429,1629147,1632864,1636580,1640295,1644009,
1647721,1651433,1655143,1658852,1662560,1666267,1669972,1673677,1677380,1681082,
1684783,1688483,1692181,1695879,1699575,1703271,1706965,1710658,1714349,1718040,
1721729,1725418,1729105,1732791,1736475,1740159,1743842,1747523,1751203,1754882,
1758560,1762237,1765912,1769587,1773260,1776932,1780603,1784273,1787941,1791610,
1795275,1798940,1802604,1806267,1809929,1813590,1817249,1820907,1824564,1828220,
1831875,1835529,1839181,1842832,1846483,1850132,1853779,1857426,1861072,1864716,
1868359,1872001,1875642,1879282,1882921,1886558,1890194,1893830,1897463,1901096,
1904728,1908359,1911988,1915616,1919243,1922869,1926494,1930117,1933740,1937361,
1940981,1944600,1948218,1951835,1955450,1959065,1962678,1966290,1969901,1973510};
    if (i < 9'(ROM1000_SIZE)) return t[i];
    return '0;
  endfunction

  function automatic logic [16:0] pt500_val(input logic [8:0] i);
    logic [16:0] t [0:ROM500_SIZE-1];
    t = '{
40352,40550,40749,40947,41145,41343,41541,41739,41937,42135,
42333,42531,42729,42926,43124,43321,43519,43716,43914,44111,
44308,44505,44702,44899,45096,45293,45490,45687,45883,46080,
46277,46473,46669,46866,47062,47258,47455,47651,47847,48043,
48239,48435,48631,48826,49022,49218,49413,49609,49805,50000,
50195,50391,50586,50781,50976,51171,51366,51561,51756,51951,
52146,52341,52536,52730,52925,53119,53314,53508,53702,53897,
54091,54285,54479,54673,54867,55061,55255,55449,55643,55836,
56030,56224,56417,56611,56804,56998,57191,57384,57577,57770,
57963,58156,58349,58542,58735,58928,59121,59313,59506,59699,
59891,60084,60276,60468,60660,60853,61045,61237,61429,61621,
61813,62005,62197,62388,62580,62772,62963,63155,63346,63538,
63729,63920,64111,64303,64494,64685,64876,65067,65258,65448,
65639,65830,66021,66211,66402,66592,66783,66973,67163,67353,
67544,67734,67924,68114,68304,68494,68684,68873,69063,69253,
69442,69632,69821,70011,70200,70390,70579,70768,70957,71146,
71335,71524,71713,71902,72091,72280,72468,72657,72845,73034,
73222,73411,73599,73787,73976,74164,74352,74540,74728,74916,
75104,75292,75479,75667,75855,76042,76230,76417,76605,76792,
76979,77167,77354,77541,77728,77915,78102,78289,78476,78663,
78849,79036,79223,79409,79596,79782,79968,80155,80341,80527,
80713,80899,81085,81271,81457,81643,81829,82015,82200,82386,
82572,82757,82943,83128,83313,83499,83684,83869,84054,84239,
84424,84609,84794,84979,85164,85348,85533,85717,85902,86086,
86271,86455,86640,86824,87008,87192,87376,87560,87744,87928,
88112,88296,88479,88663,88847,89030,89214,89397,89580,89764,
89947,90130,90313,90496,90679,90862,91045,91228,91411,91594,
91776,91959,92142,92324,92507,92689,92871,93054,93236,93418,
93600,93782,93964,94146,94328,94510,94691,94873,95055,95236,
95418,95599,95781,95962,96143,96325,96506,96687,96868,97049,
97230,97411,97592,97773,97953,98134,98314,98495,98676,98856,
99036,99217,99397,99577,99757,99937,100117,100297,100477,100657,
100837,101017,101196,101376,101555,101735,101914,102094,102273,102452,
102632,102811,102990,103169,103348,103527,103706,103885,104063,104242,
104421,104599,104778,104956,105135,105313,105491,105669,105848,106026,
106204,106382,106560,106738,106915,107093,107271,107449,107626,107804,
107981,108159,108336,108513,108691,108868,109045,109222,109399,109576,
109753,109930,110107,110283,110460,110637,110813,110990,111166,111342,
111519,111695,111871,112047,112224,112400,112576,112751,112927,113103,
113279,113455,113630,113806,113981,114157,114332,114508,114683,114858,
115033,115208,115383,115558,115733,115908,116083,116258,116433,116607,
116782,116956,117131,117305,117480,117654,117828,118002,118176,118351,
118525,118699,118872,119046,119220,119394,119567,119741,119915,120088,
120262,120435,120608,120782,120955,121128,121301,121474,121647,121820,
121993,122166,122338,122511,122684,122856,123029,123201,123374,123546,
123718,123891,124063,124235,124407,124579,124751,124923,125094,125266};
    if (i < 9'(ROM500_SIZE)) return t[i];
    return '0;
  endfunction

endpackage

[rtl/rtd_trimmed_mean_temperature_top.sv]
// ----------------------------------------------------------------------------
// rtd_trimmed_mean_temperature_top: trimmed-mean RTD temperature block
// Windowed converter samples to a table index of temperature.
// ----------------------------------------------------------------------------
// Words are taken while the window fills and no result waits; the window's last
// word starts the computation and input stalls until its result is taken. The
// computation runs the in-RAM transposition sort (one RAM port), the sum, the
// average by reciprocal multiplication and the voltage scale, the bridge voltage
// and search set-up, the table search (up to 9 steps) and the loading of the
// result. A bad select on a window's first word gives an error word at once and
// starts no window.
module rtd_trimmed_mean_temperature_top #(
  parameter int unsigned WINDOW   = rtdtm_pkg::WINDOW_DEF,
  parameter int unsigned TRIM     = rtdtm_pkg::TRIM_DEF,
  parameter int unsigned PT1000_N = rtdtm_pkg::PT1000_N_DEF,
  parameter int unsigned PT500_N  = rtdtm_pkg::PT500_N_DEF,
  parameter int unsigned SBITS    = rtdtm_pkg::SBITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtdtm_pkg::in_word_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtdtm_pkg::out_word_t  out_data_o
);
  rtdtm_pkg::cmd_t  cmd;
  rtdtm_pkg::stat_t stat;
  logic [$clog2(WINDOW)-1:0] wa;
  logic pt5, err, ut, cap;
  logic [7:0] t_dp, t_q;
  logic [15:0] smp;

  // keep only the used sample bits
  assign smp = in_data_i.sample & 16'((17'd1 << SBITS) - 17'd1);

  rtdtm_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .sel_i(in_data_i.sensor_select), .in_stall_o,
    .out_valid_o, .out_stall_i, .out_err_o(err), .out_use_temp_o(ut), .cap_o(cap),
    .stat_i(stat), .cmd_o(cmd), .wr_addr_o(wa), .pt500_o(pt5)
  );

  rtdtm_datapath #(.WINDOW(WINDOW), .TRIM(TRIM), .PT1000_N(PT1000_N),
                   .PT500_N(PT500_N), .SBITS(SBITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(smp), .wr_addr_i(wa), .pt500_i(pt5),
    .stat_o(stat), .temp_o(t_dp)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cap) t_q <= t_dp;
  end

  assign out_data_o.temperature = ut ? t_q : rtdtm_pkg::ERR_CODE;
  assign out_data_o.error       = err;
endmodule

[rtl/rtdtm_ram.sv]
// ----------------------------------------------------------------------------
// rtdtm_ram: generic single-port RAM
// One write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module rtdtm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/rtdtm_datapath.sv]
// ----------------------------------------------------------------------------
// rtdtm_datapath: sample store, sorter, averager, scaler and table search
// Sort is an odd-even transposition over the store, compare-swap passes
// through the RAM; sum and compare run one element per step.
// ----------------------------------------------------------------------------
module rtdtm_datapath #(
  parameter int unsigned WINDOW     = rtdtm_pkg::WINDOW_DEF,
  parameter int unsigned TRIM       = rtdtm_pkg::TRIM_DEF,
  parameter int unsigned PT1000_N   = rtdtm_pkg::PT1000_N_DEF,
  parameter int unsigned PT500_N    = rtdtm_pkg::PT500_N_DEF,
  parameter int unsigned SBITS      = rtdtm_pkg::SBITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtdtm_pkg::cmd_t    cmd_i,
  input  logic [15:0]        sample_i,
  input  logic [$clog2(WINDOW)-1:0] wr_addr_i,
  input  logic               pt500_i,
  output rtdtm_pkg::stat_t   stat_o,
  output logic [7:0]         temp_o
);
  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned TR   = (WINDOW <= 2 * TRIM) ? (WINDOW - 1) / 2 : TRIM;
  localparam int unsigned CNT  = WINDOW - 2 * TR;
  localparam int unsigned SUMW = 16 + $clog2(WINDOW + 1);
  localparam int unsigned N1   = (PT1000_N > rtdtm_pkg::ROM1000_SIZE) ?
                                 rtdtm_pkg::ROM1000_SIZE : PT1000_N;
  localparam int unsigned N5   = (PT500_N > rtdtm_pkg::ROM500_SIZE) ?
                                 rtdtm_pkg::ROM500_SIZE : PT500_N;
  // passes: WINDOW passes, alternately over the even-indexed and odd-indexed pairs
  localparam int unsigned PW   = $clog2(WINDOW + 1);
  // reciprocal of CNT, exact for every SUMW-bit sum
  localparam int unsigned DSH  = SUMW + $clog2(CNT);
  localparam longint unsigned DREC = ((64'd1 << DSH) + 64'(CNT) - 64'd1) / 64'(CNT);
  // reciprocals of 5 (13-bit voltage) and 343 (20-bit voltage times 50)
  localparam longint unsigned R5   = ((64'd1 << 16) + 64'd4) / 64'd5;
  localparam longint unsigned R343 = ((64'd1 << 29) + 64'd342) / 64'd343;

  // sort addressing: phase 0 read a, 1 read b, 2 write a, 3 write b
  logic [PW-1:0] pass_q;
  logic [AW-1:0] idx_q;
  logic [1:0]    ph_q;
  logic [15:0]   va_q, rdat;
  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wdat;
  logic [15:0]   lo_v, hi_v;

  assign lo_v = (va_q > rdat) ? rdat : va_q;
  assign hi_v = (va_q > rdat) ? va_q : rdat;

  // sum
  logic [AW:0]      sidx_q;
  logic [SUMW-1:0]  sum_q;
  // average by reciprocal multiply, then voltage, one stage each
  logic [SUMW-1:0]  quo_q;
  logic [2*SUMW:0]  qprod;
  logic [1:0]       dcnt_q;
  // scale
  logic [13:0]      m_q, h_q;
  logic [SUMW+12:0] vprod;
  logic [12:0]      v_q;
  logic [19:0]      v50;
  logic [29:0]      v5p;
  logic [40:0]      v343p;
  logic [13:0]      m_d;
  // search
  logic [8:0]       lo_q, hi_q, mid_q;
  logic [8:0]       mid;
  logic [9:0]       mid_sum;
  logic [36:0]      lhs_q, rhs_q;
  logic [20:0]      tval, tval_q;
  logic             res_lt_q, res_eq_q;

  always_comb begin
    we   = 1'b0;
    addr = wr_addr_i;
    wdat = sample_i;
    if (cmd_i.store_wr) begin
      we = 1'b1;
    end else if (cmd_i.sort_step) begin
      case (ph_q)
        2'd0: addr = idx_q;
        2'd1: addr = idx_q + AW'(1);
        2'd2: begin addr = idx_q; we = 1'b1; wdat = lo_v; end
        default: begin addr = idx_q + AW'(1); we = 1'b1; wdat = va_q; end
      endcase
    end else if (cmd_i.rd_issue) begin
      addr = sidx_q[AW-1:0];
    end
  end

  rtdtm_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdat), .rdata_o(rdat)
  );

  // midpoint without overflow; table read registered at issue
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[9:1];
  assign tval = pt500_i ? (21'(rtdtm_pkg::pt500_val(mid)) + 21'd1000)
                        : rtdtm_pkg::pt1000_val(mid);

  // average: sum / CNT
  assign qprod = (2*SUMW+1)'(sum_q) * (2*SUMW+1)'(DREC);

  // scale: v = avg*5000 >> SBITS
  assign vprod = (SUMW+13)'(quo_q) * (SUMW+13)'(5000);
  assign v50   = 20'(v_q) * 20'd50;
  assign v5p   = 30'(v_q) * 30'(R5);
  assign v343p = 41'(v50) * 41'(R343);
  always_comb begin
    if (pt500_i) m_d = 14'(v343p >> 29) + 14'd927;
    else         m_d = 14'(v5p >> 16) + 14'd1389;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0; idx_q <= '0; ph_q <= '0; sidx_q <= '0; dcnt_q <= '0;
    end else begin
      if (cmd_i.sort_init) begin
        pass_q <= '0; idx_q <= '0; ph_q <= '0;
      end else if (cmd_i.sort_step) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          if (idx_q >= AW'(WINDOW - 3)) begin
            idx_q  <= AW'(pass_q[0] ? 0 : 1);
            pass_q <= pass_q + PW'(1);
          end else begin
            idx_q <= idx_q + AW'(2);
          end
        end
      end
      if (cmd_i.sum_init)      sidx_q <= (AW+1)'(TR);
      else if (cmd_i.rd_issue) sidx_q <= sidx_q + (AW+1)'(1);
      if (cmd_i.div_start)     dcnt_q <= '0;
      else if (!stat_o.div_done) dcnt_q <= dcnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_step && ph_q == 2'd2) va_q <= hi_v;
    else if (cmd_i.sort_step && ph_q == 2'd1) va_q <= rdat;
    if (cmd_i.sum_init)     sum_q <= '0;
    else if (cmd_i.sum_acc) sum_q <= sum_q + SUMW'(rdat);
    quo_q <= SUMW'(qprod >> DSH);
    v_q   <= 13'(vprod >> SBITS);
    if (cmd_i.scale) begin
      m_q <= m_d; h_q <= 14'd10000 - m_d;
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= pt500_i ? 9'(N5 - 1) : 9'(N1 - 1);
    end else if (cmd_i.cmp_issue) begin
      mid_q  <= mid;
      tval_q <= tval;
    end else if (cmd_i.cmp_apply) begin
      if (res_lt_q) hi_q <= mid_q; else lo_q <= mid_q;
    end
    lhs_q <= pt500_i ? 37'(m_q) * 37'd499000 : 37'(m_q) * 37'd6200000;
    rhs_q <= 37'(tval_q) * 37'(h_q);
  end

  assign res_lt_q = lhs_q < rhs_q;
  assign res_eq_q = lhs_q == rhs_q;

  assign stat_o.sort_done  = (pass_q == PW'(WINDOW));
  assign stat_o.sum_done   = (sidx_q == (AW+1)'(TR + CNT));
  assign stat_o.div_done   = (dcnt_q == 2'd2);
  assign stat_o.over_limit = (m_q > 14'd10000);
  assign stat_o.srch_done  = (hi_q - lo_q) <= 9'd1;
  assign stat_o.hit        = res_eq_q;

  always_comb begin
    logic [8:0] r;
    r = res_eq_q && cmd_i.cmp_apply ? mid_q : lo_q;
    temp_o = pt500_i ? 8'(r - 9'd49) : r[7:0];
  end
endmodule

[rtl/rtdtm_ctrl.sv]
// ----------------------------------------------------------------------------
// rtdtm_ctrl: window sequencer
// Collects the window, then steps sort, sum, divide, scale and search.
// ----------------------------------------------------------------------------
module rtdtm_ctrl #(
  parameter int unsigned WINDOW = rtdtm_pkg::WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          sel_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                out_err_o,
  output logic                out_use_temp_o,
  output logic                cap_o,
  input  rtdtm_pkg::stat_t    stat_i,
  output rtdtm_pkg::cmd_t     cmd_o,
  output logic [$clog2(WINDOW)-1:0] wr_addr_o,
  output logic                pt500_o
);
  localparam int unsigned AW = $clog2(WINDOW);

  rtdtm_pkg::state_e st_q, st_d;
  logic [AW-1:0] cnt_q;
  logic [2:0]    sel_q;
  logic          ov_q, err_q, ut_q;
  logic          acc, bad, last;

  assign in_stall_o = (st_q != rtdtm_pkg::ST_FILL) || ov_q;
  assign acc  = in_valid_i && !in_stall_o;
  assign bad  = (cnt_q == '0) && !(sel_i inside {[3'd1:3'd5]});
  assign last = (cnt_q == AW'(WINDOW - 1));
  assign wr_addr_o = cnt_q;
  assign pt500_o = (sel_q == rtdtm_pkg::SEL_PT500);
  assign out_valid_o = ov_q;
  assign out_err_o = err_q;
  assign out_use_temp_o = ut_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      rtdtm_pkg::ST_FILL:     if (acc && !bad && last) st_d = rtdtm_pkg::ST_SORT_CMP;
      rtdtm_pkg::ST_SORT_CMP: if (stat_i.sort_done) st_d = rtdtm_pkg::ST_SUM_RD;
      rtdtm_pkg::ST_SUM_RD:   st_d = rtdtm_pkg::ST_SUM;
      rtdtm_pkg::ST_SUM:      if (stat_i.sum_done) st_d = rtdtm_pkg::ST_DIV;
      rtdtm_pkg::ST_DIV:      if (stat_i.div_done) st_d = rtdtm_pkg::ST_SCALE;
      rtdtm_pkg::ST_SCALE:    st_d = rtdtm_pkg::ST_SORT_WR;
      rtdtm_pkg::ST_SORT_WR:  st_d = stat_i.over_limit ? rtdtm_pkg::ST_FILL
                                                       : rtdtm_pkg::ST_SRCH;
      rtdtm_pkg::ST_SRCH:     st_d = stat_i.srch_done ? rtdtm_pkg::ST_FILL
                                                      : rtdtm_pkg::ST_SORT_RD;
      rtdtm_pkg::ST_SORT_RD:  st_d = rtdtm_pkg::ST_CMP;
      rtdtm_pkg::ST_CMP:      st_d = rtdtm_pkg::ST_OUT;
      rtdtm_pkg::ST_OUT:      st_d = stat_i.hit ? rtdtm_pkg::ST_FILL : rtdtm_pkg::ST_SRCH;
      default:                st_d = rtdtm_pkg::ST_FILL;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cap_o = 1'b0;
    case (st_q)
      rtdtm_pkg::ST_FILL:     begin
        cmd_o.store_wr = acc && !bad;
        cmd_o.sort_init = 1'b1;
      end
      rtdtm_pkg::ST_SORT_CMP: begin
        cmd_o.sort_step = !stat_i.sort_done;
        cmd_o.sum_init  = stat_i.sort_done;
      end
      rtdtm_pkg::ST_SUM_RD:   cmd_o.rd_issue = 1'b1;
      rtdtm_pkg::ST_SUM:      begin
        cmd_o.sum_acc   = 1'b1;
        cmd_o.rd_issue  = !stat_i.sum_done;
        cmd_o.div_start = stat_i.sum_done;
      end
      rtdtm_pkg::ST_SCALE:    cmd_o.scale = 1'b1;
      rtdtm_pkg::ST_SORT_WR:  cmd_o.srch_init = 1'b1;
      rtdtm_pkg::ST_SRCH:     cap_o = stat_i.srch_done;
      rtdtm_pkg::ST_SORT_RD:  cmd_o.cmp_issue = 1'b1;
      rtdtm_pkg::ST_OUT:      begin
        cmd_o.cmp_apply = 1'b1;
        cap_o = stat_i.hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rtdtm_pkg::ST_FILL; cnt_q <= '0; sel_q <= '0;
      ov_q <= 1'b0; err_q <= 1'b0; ut_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (acc) begin
        if (bad) begin
          ov_q <= 1'b1; err_q <= 1'b1; ut_q <= 1'b0;
        end else begin
          if (cnt_q == '0) sel_q <= sel_i;
          cnt_q <= last ? '0 : cnt_q + AW'(1);
        end
      end
      if (st_q == rtdtm_pkg::ST_SORT_WR && stat_i.over_limit) begin
        ov_q <= 1'b1; err_q <= 1'b1; ut_q <= 1'b0;
      end
      if (cap_o) begin
        ov_q <= 1'b1; err_q <= 1'b0; ut_q <= 1'b1;
      end
    end
  end
endmodule

[rtl/rtdtm_checker.sv]
// ----------------------------------------------------------------------------
// rtdtm_checker: port-level checks
// Watches the top-level ports only.
// ----------------------------------------------------------------------------
module rtdtm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input rtdtm_pkg::out_word_t out_data_o
);
  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");
  // an error word always carries the error code
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.temperature == 8'd255)
    else $error("error word without error code");
  // no input taken while a result waits
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");
endmodule

bind rtd_trimmed_mean_temperature_top rtdtm_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
